FILE: rtl/gfdsn_pkg.sv
`default_nettype none

package gfdsn_pkg;

    localparam logic [7:0] ID_ANALOG  = 8'h73;
    localparam logic [7:0] ID_DIGITAL = 8'h41;
    localparam logic [7:0] ACK_OK     = 8'h5A;

    localparam logic [11:0] POS_MAX   = 12'd2500;
    localparam logic [11:0] POS_MIN   = 12'd500;
    localparam logic [11:0] POS_RESET = 12'd1500;
    localparam logic [11:0] AXIS_MID  = 12'd1023;

    localparam logic [9:0] DEADBAND_RESET   = 10'd100;
    localparam logic [7:0] SERVO_STEP_RESET = 8'd10;

    localparam logic [1:0] REG_DEADBAND   = 2'd0;
    localparam logic [1:0] REG_SERVO_STEP = 2'd1;

    localparam logic [1:0] STATUS_DECODED = 2'd0;
    localparam logic [1:0] STATUS_DIGITAL = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam int BIT_L2    = 0;
    localparam int BIT_L1    = 2;
    localparam int BIT_UP    = 4;
    localparam int BIT_RIGHT = 5;
    localparam int BIT_DOWN  = 6;
    localparam int BIT_LEFT  = 7;

    typedef struct packed {
        logic [7:0] id_byte;
        logic [7:0] ack_byte;
        logic [7:0] buttons_low;
        logic [7:0] buttons_high;
        logic [7:0] rotate_raw;
        logic [7:0] forward_raw;
        logic [7:0] side_raw;
    } frame_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] speed_x;
        logic [10:0] speed_y;
        logic [10:0] speed_rot;
        logic [11:0] servo_a;
        logic [11:0] servo_b;
        logic [11:0] servo_c;
    } result_t;

    // The raise move is applied first, then the lower move; both saturate.
    function automatic logic [11:0] nudge(input logic [11:0] pos, input logic [7:0] step,
                                          input logic raise, input logic lower);
        logic [12:0] sum;
        logic [12:0] floor_lim;
        logic [11:0] p;
        begin
            p = pos;
            sum = {1'b0, p} + {5'd0, step};
            if (raise)
            begin
                p = (sum >= {1'b0, POS_MAX}) ? POS_MAX : sum[11:0];
            end
            floor_lim = {1'b0, POS_MIN} + {5'd0, step};
            if (lower)
            begin
                p = ({1'b0, p} <= floor_lim) ? POS_MIN : (p - {4'd0, step});
            end
            return p;
        end
    endfunction

    // Speed is raw*8 - 1023, or its negation when inverted, zeroed inside the deadband.
    function automatic logic [10:0] axis_speed(input logic [7:0] raw, input logic invert,
                                               input logic [9:0] deadband);
        logic [11:0] scaled;
        logic [11:0] v;
        logic [11:0] mag;
        begin
            scaled = {1'b0, raw, 3'b000};
            v = invert ? (AXIS_MID - scaled) : (scaled - AXIS_MID);
            mag = v[11] ? (12'd0 - v) : v;
            return (mag <= {2'b00, deadband}) ? 11'd0 : v[10:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gamepad_frame_decode_servo_nudge.sv
`default_nettype none

// An accepted input transaction is captured in the input register, and its result
// is then registered in the result register, from which the outputs are driven.
// Throughput: one frame per cycle with out_ready high; input and result registers form a
// two-stage pipeline, and the stored servo positions update as a frame leaves stage one.
// Reset: deadband returns to 100, servo step to 10, all servo positions to 1500,
// and both pipeline stages are emptied.
module gamepad_frame_decode_servo_nudge
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,

    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [7:0]  id_byte,
    input  wire logic [7:0]  ack_byte,
    input  wire logic [7:0]  buttons_low,
    input  wire logic [7:0]  buttons_high,
    input  wire logic [7:0]  rotate_raw,
    input  wire logic [7:0]  forward_raw,
    input  wire logic [7:0]  side_raw,

    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [1:0]  status,
    output      logic [10:0] speed_x,
    output      logic [10:0] speed_y,
    output      logic [10:0] speed_rot,
    output      logic [11:0] servo_a,
    output      logic [11:0] servo_b,
    output      logic [11:0] servo_c
);

    logic [9:0]  deadband_reg;
    logic [7:0]  servo_step_reg;
    logic [11:0] servo_a_pos_reg;
    logic [11:0] servo_b_pos_reg;
    logic [11:0] servo_c_pos_reg;

    logic                 frame_valid_reg;
    gfdsn_pkg::frame_t    frame_reg;
    logic                 result_valid_reg;
    gfdsn_pkg::result_t   result_reg;
    gfdsn_pkg::result_t   result_next;

    logic frame_advance;
    logic is_decoded;
    logic is_digital;

    assign frame_advance = frame_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready      = !frame_valid_reg || frame_advance;

    assign is_decoded = (frame_reg.id_byte == gfdsn_pkg::ID_ANALOG)
                        && (frame_reg.ack_byte == gfdsn_pkg::ACK_OK);
    assign is_digital = (frame_reg.id_byte == gfdsn_pkg::ID_DIGITAL)
                        && (frame_reg.ack_byte == gfdsn_pkg::ACK_OK);

    always_comb
    begin
        result_next.servo_a   = servo_a_pos_reg;
        result_next.servo_b   = servo_b_pos_reg;
        result_next.servo_c   = servo_c_pos_reg;
        result_next.speed_x   = 11'd0;
        result_next.speed_y   = 11'd0;
        result_next.speed_rot = 11'd0;
        if (is_decoded)
        begin
            result_next.status  = gfdsn_pkg::STATUS_DECODED;
            result_next.servo_a = gfdsn_pkg::nudge(servo_a_pos_reg, servo_step_reg,
                                      !frame_reg.buttons_high[gfdsn_pkg::BIT_L1],
                                      !frame_reg.buttons_high[gfdsn_pkg::BIT_L2]);
            result_next.servo_b = gfdsn_pkg::nudge(servo_b_pos_reg, servo_step_reg,
                                      !frame_reg.buttons_low[gfdsn_pkg::BIT_UP],
                                      !frame_reg.buttons_low[gfdsn_pkg::BIT_DOWN]);
            result_next.servo_c = gfdsn_pkg::nudge(servo_c_pos_reg, servo_step_reg,
                                      !frame_reg.buttons_low[gfdsn_pkg::BIT_LEFT],
                                      !frame_reg.buttons_low[gfdsn_pkg::BIT_RIGHT]);
            result_next.speed_x   = gfdsn_pkg::axis_speed(frame_reg.side_raw, 1'b1,
                                                          deadband_reg);
            result_next.speed_y   = gfdsn_pkg::axis_speed(frame_reg.forward_raw, 1'b0,
                                                          deadband_reg);
            result_next.speed_rot = gfdsn_pkg::axis_speed(frame_reg.rotate_raw, 1'b0,
                                                          deadband_reg);
        end
        else if (is_digital)
        begin
            result_next.status = gfdsn_pkg::STATUS_DIGITAL;
        end
        else
        begin
            result_next.status = gfdsn_pkg::STATUS_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg   <= gfdsn_pkg::DEADBAND_RESET;
            servo_step_reg <= gfdsn_pkg::SERVO_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gfdsn_pkg::REG_DEADBAND:
                begin
                    deadband_reg <= cfg_data;
                end
                gfdsn_pkg::REG_SERVO_STEP:
                begin
                    servo_step_reg <= cfg_data[7:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_a_pos_reg  <= gfdsn_pkg::POS_RESET;
            servo_b_pos_reg  <= gfdsn_pkg::POS_RESET;
            servo_c_pos_reg  <= gfdsn_pkg::POS_RESET;
            frame_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                frame_valid_reg <= in_valid;
            end
            if (frame_advance)
            begin
                servo_a_pos_reg  <= result_next.servo_a;
                servo_b_pos_reg  <= result_next.servo_b;
                servo_c_pos_reg  <= result_next.servo_c;
                result_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            frame_reg.id_byte      <= id_byte;
            frame_reg.ack_byte     <= ack_byte;
            frame_reg.buttons_low  <= buttons_low;
            frame_reg.buttons_high <= buttons_high;
            frame_reg.rotate_raw   <= rotate_raw;
            frame_reg.forward_raw  <= forward_raw;
            frame_reg.side_raw     <= side_raw;
        end
        if (frame_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = result_valid_reg;
    assign status    = result_reg.status;
    assign speed_x   = result_reg.speed_x;
    assign speed_y   = result_reg.speed_y;
    assign speed_rot = result_reg.speed_rot;
    assign servo_a   = result_reg.servo_a;
    assign servo_b   = result_reg.servo_b;
    assign servo_c   = result_reg.servo_c;

endmodule

`default_nettype wire
